// ----- rtl/msrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrp_pkg
// Shared constants, result beat type and CRC-16/Modbus byte update.
// ----------------------------------------------------------------------------
package msrp_pkg;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  ADDR_BYTE  = 8'h01;
   localparam logic [7:0]  FUNC_BYTE  = 8'h03;
   localparam logic [7:0]  COUNT_BYTE = 8'h02;

   typedef struct packed {
      logic [2:0]  next_position;
      logic        frame_accepted;
      logic [15:0] reading_tenths;
   } result_type;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/msrp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrp_parser
// Frame position tracker, running CRC and reading latch; one byte per beat.
// ----------------------------------------------------------------------------
module msrp_parser import msrp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       beat,
   input  logic [7:0] rx_byte,
   output result_type result
);

   typedef enum logic [6:0] {
      POS_ADDR   = 7'b0000001,
      POS_FUNC   = 7'b0000010,
      POS_COUNT  = 7'b0000100,
      POS_VAL_HI = 7'b0001000,
      POS_VAL_LO = 7'b0010000,
      POS_CRC_LO = 7'b0100000,
      POS_CRC_HI = 7'b1000000
   } pos_type;

   pos_type     pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  value_high_ff, value_high_in;
   logic [7:0]  value_low_ff, value_low_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [15:0] reading_ff, reading_in;
   logic        accepted;
   logic [15:0] crc_next;
   logic [2:0]  pos_code;

   assign crc_next = crc16_update(crc_ff, rx_byte);

   always_comb begin
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      value_high_in = value_high_ff;
      value_low_in  = value_low_ff;
      crc_low_in    = crc_low_ff;
      reading_in    = reading_ff;
      accepted      = 1'b0;
      unique case (pos_ff)
         POS_ADDR: begin
            if (rx_byte == ADDR_BYTE) begin
               crc_in = crc_next;
               pos_in = POS_FUNC;
            end else begin
               crc_in = CRC_INIT;
               pos_in = POS_ADDR;
            end
         end
         POS_FUNC: begin
            if (rx_byte == FUNC_BYTE) begin
               crc_in = crc_next;
               pos_in = POS_COUNT;
            end else begin
               crc_in = CRC_INIT;
               pos_in = POS_ADDR;
            end
         end
         POS_COUNT: begin
            if (rx_byte == COUNT_BYTE) begin
               crc_in = crc_next;
               pos_in = POS_VAL_HI;
            end else begin
               crc_in = CRC_INIT;
               pos_in = POS_ADDR;
            end
         end
         POS_VAL_HI: begin
            value_high_in = rx_byte;
            crc_in        = crc_next;
            pos_in        = POS_VAL_LO;
         end
         POS_VAL_LO: begin
            value_low_in = rx_byte;
            crc_in       = crc_next;
            pos_in       = POS_CRC_LO;
         end
         POS_CRC_LO: begin
            crc_low_in = rx_byte;
            pos_in     = POS_CRC_HI;
         end
         POS_CRC_HI: begin
            if (crc_ff == {rx_byte, crc_low_ff}) begin
               reading_in = {value_high_ff, value_low_ff};
               accepted   = 1'b1;
            end
            crc_in = CRC_INIT;
            pos_in = POS_ADDR;
         end
         default: begin
            crc_in = CRC_INIT;
            pos_in = POS_ADDR;
         end
      endcase
   end

   always_comb begin
      unique case (pos_in)
         POS_ADDR:   pos_code = 3'd0;
         POS_FUNC:   pos_code = 3'd1;
         POS_COUNT:  pos_code = 3'd2;
         POS_VAL_HI: pos_code = 3'd3;
         POS_VAL_LO: pos_code = 3'd4;
         POS_CRC_LO: pos_code = 3'd5;
         POS_CRC_HI: pos_code = 3'd6;
         default:    pos_code = 3'd0;
      endcase
   end

   assign result.next_position  = pos_code;
   assign result.frame_accepted = accepted;
   assign result.reading_tenths = reading_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_ADDR;
         crc_ff     <= CRC_INIT;
         reading_ff <= 16'h0000;
      end else if (beat) begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         reading_ff <= reading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat) begin
         value_high_ff <= value_high_in;
         value_low_ff  <= value_low_in;
         crc_low_ff    <= crc_low_in;
      end
   end

endmodule

// ----- rtl/modbus_sensor_reply_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_sensor_reply_parser_core
// Recognizes a 7-byte Modbus RTU read reply in a received byte stream.
// ----------------------------------------------------------------------------
// usage
//   req channel: one received serial byte per beat on req_rx_byte.
//   rsp channel: one result beat per request beat, in order, carrying the
//   next frame position, a flag for a frame completed with matching CRC,
//   and the last accepted reading in raw tenths.
//   output: each result is registered in the output register, or in the skid register.
//   throughput: one byte per cycle while req_ready is high; the update of
//   position/CRC is one combinational step from parser state to output register.
//   stalls: an output register plus a skid register sit on the rsp side,
//   so one more byte is taken while a result waits; req_ready drops only
//   when both hold results.
//   reset: synchronous; position returns to start, CRC to 0xFFFF, reading
//   to zero and both output stages empty.
// ----------------------------------------------------------------------------
module modbus_sensor_reply_parser_core import msrp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_next_position,
   output logic        rsp_frame_accepted,
   output logic [15:0] rsp_reading_tenths
);

   result_type new_result;
   result_type out_ff, skid_ff;
   logic       out_valid_ff, skid_valid_ff;
   logic       fire_in, fire_out;

   assign req_ready = ~skid_valid_ff;
   assign fire_in   = req_valid & req_ready;
   assign fire_out  = out_valid_ff & rsp_ready;

   msrp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .beat    (fire_in),
      .rx_byte (req_rx_byte),
      .result  (new_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || fire_out) begin
         out_valid_ff  <= skid_valid_ff | fire_in;
         skid_valid_ff <= 1'b0;
      end else if (fire_in) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || fire_out) begin
         out_ff <= skid_valid_ff ? skid_ff : new_result;
      end else if (fire_in) begin
         skid_ff <= new_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_next_position  = out_ff.next_position;
   assign rsp_frame_accepted = out_ff.frame_accepted;
   assign rsp_reading_tenths = out_ff.reading_tenths;

endmodule
